@@ rtl/divider_64bit_signed_unsigned_assert.svh @@
// ----------------------------------------------------------------------------
// divider assertion macros
// shared assertion forms for the divider pipeline
// ----------------------------------------------------------------------------
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_ASSERT_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_ASSERT_SVH

// implication checked on every edge outside reset
`define DIV_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define DIV_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ rtl/div_pkg.sv @@
// ----------------------------------------------------------------------------
// divider package
// shared op codes, widths and pipeline control type
// ----------------------------------------------------------------------------
package div_pkg;
  localparam int unsigned DataW    = 64;
  localparam int unsigned DefWidth = 64;

  localparam logic [1:0] OpDivU = 2'd0;
  localparam logic [1:0] OpRemU = 2'd1;
  localparam logic [1:0] OpDivS = 2'd2;
  localparam logic [1:0] OpRemS = 2'd3;

  // control riding with each word through the pipeline
  typedef struct packed {
    logic want_rem;
    logic neg_quot;
    logic neg_rem;
    logic zero_div;
  } div_ctl_t;
endpackage

@@ rtl/div_stage.sv @@
// ----------------------------------------------------------------------------
// divider stage
// one restoring step: shift in a dividend bit, trial subtract, set quotient bit
// ----------------------------------------------------------------------------
module div_stage import div_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  div_ctl_t         ctl_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  output logic             valid_o,
  output div_ctl_t         ctl_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] num_o,
  output logic [WIDTH-1:0] den_o
);
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             take;
  logic [WIDTH-1:0] rem_d;
  logic [WIDTH-1:0] num_d;
  logic             valid_q;
  div_ctl_t         ctl_q;
  logic [WIDTH-1:0] rem_q, num_q, den_q;

  // num holds the unconsumed dividend bits on top, quotient bits filling below
  assign shifted = {rem_i, num_i[WIDTH-1]};
  assign diff    = shifted - {1'b0, den_i};
  assign take    = ~diff[WIDTH];
  assign rem_d   = take ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
  assign num_d   = {num_i[WIDTH-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_i;
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_i;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
endmodule

@@ rtl/divider_64bit_signed_unsigned.sv @@
// ----------------------------------------------------------------------------
// 64-bit signed/unsigned divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
// usage: drive op_i, dividend_i and divisor_i with start high; the word is
// taken at the edge where start is high and busy is low. busy is always
// low: a new word may enter every cycle.
// path to done_o: one input register, loaded at the accepting edge, that
// takes magnitudes, then WIDTH restoring stages, then one output register
// that applies signs and raises done_o. the result is on result_o for
// exactly one cycle while done_o is high.
// throughput: one word per cycle; WIDTH stages each retire one quotient bit,
// so the subtractor chain, not a shared unit, sets the depth.
// zero divisor gives 0 for every op. the most negative operand divides as
// 2^(WIDTH-1) unsigned, and negated results wrap.
// reset clears all valid bits; words in flight are dropped.
// the receiver cannot stall: done_o is a strobe and must be taken.
// ----------------------------------------------------------------------------
`include "divider_64bit_signed_unsigned_assert.svh"
module divider_64bit_signed_unsigned import div_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] result_o
);
  logic [WIDTH-1:0] a, b, a_mag, b_mag;
  logic             is_signed, a_neg, b_neg;

  logic             v_in_q;
  div_ctl_t         ctl_in_q;
  logic [WIDTH-1:0] num_in_q, den_in_q;

  logic             v_s   [WIDTH+1];
  div_ctl_t         ctl_s [WIDTH+1];
  logic [WIDTH-1:0] rem_s [WIDTH+1];
  logic [WIDTH-1:0] num_s [WIDTH+1];
  logic [WIDTH-1:0] den_s [WIDTH+1];

  logic             done_q;
  logic [WIDTH-1:0] res_d, res_q;

  assign busy = 1'b0;

  // input stage: take magnitudes for signed ops
  assign a         = dividend_i[WIDTH-1:0];
  assign b         = divisor_i[WIDTH-1:0];
  assign is_signed = (op_i == OpDivS) || (op_i == OpRemS);
  assign a_neg     = is_signed & a[WIDTH-1];
  assign b_neg     = is_signed & b[WIDTH-1];
  assign a_mag     = a_neg ? (~a + 1'b1) : a;
  assign b_mag     = b_neg ? (~b + 1'b1) : b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q <= 1'b0;
    end else begin
      v_in_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_in_q.want_rem <= (op_i == OpRemU) || (op_i == OpRemS);
    ctl_in_q.neg_quot <= a_neg ^ b_neg;
    ctl_in_q.neg_rem  <= a_neg;
    ctl_in_q.zero_div <= (b == '0);
    num_in_q          <= a_mag;
    den_in_q          <= b_mag;
  end

  assign v_s[0]   = v_in_q;
  assign ctl_s[0] = ctl_in_q;
  assign rem_s[0] = '0;
  assign num_s[0] = num_in_q;
  assign den_s[0] = den_in_q;

  // restoring stages, msb first
  for (genvar g = 0; g < WIDTH; g++) begin : g_stage
    div_stage #(.WIDTH(WIDTH)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v_s[g]),
      .ctl_i  (ctl_s[g]),
      .rem_i  (rem_s[g]),
      .num_i  (num_s[g]),
      .den_i  (den_s[g]),
      .valid_o(v_s[g+1]),
      .ctl_o  (ctl_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .num_o  (num_s[g+1]),
      .den_o  (den_s[g+1])
    );
  end

  // output stage: select, fix sign, zero on zero divisor
  always_comb begin
    priority if (ctl_s[WIDTH].zero_div) begin
      res_d = '0;
    end else if (ctl_s[WIDTH].want_rem) begin
      res_d = ctl_s[WIDTH].neg_rem ? (~rem_s[WIDTH] + 1'b1) : rem_s[WIDTH];
    end else begin
      res_d = ctl_s[WIDTH].neg_quot ? (~num_s[WIDTH] + 1'b1) : num_s[WIDTH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_s[WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = DataW'(res_q);

  `DIV_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy)
  `DIV_ASSERT_NXT(a_in_valid, clk_i, rst_ni, start, v_in_q)
  `DIV_ASSERT_NXT(a_out_valid, clk_i, rst_ni, v_s[WIDTH], done_o)
  `DIV_ASSERT_NXT(a_zero_res, clk_i, rst_ni, v_s[WIDTH] && ctl_s[WIDTH].zero_div,
                  result_o == '0)
endmodule
